FILE: rtl/rgb422_pkg.sv
// Package for the RGB pair to YCbCr 4:2:2 converter: fixed-point weights,
// reciprocal constants, stage payload types and the arithmetic helpers.
// No dependencies.
`default_nettype none

package rgb422_pkg;

   localparam int LumaNumWidth   = 18;   // 1000 * 255 < 2**18
   localparam int ChromaNumWidth = 25;   // 100000 * 255 + 99999 < 2**25

   // luma weights, sum is 1000
   localparam int LumaWr = 299;
   localparam int LumaWg = 587;
   localparam int LumaWb = 114;
   localparam int LumaDiv = 1000;

   // chroma weights; the negative ones of each row sum to 50000
   localparam int CbWr = 16874;
   localparam int CbWg = 33126;
   localparam int CbWb = 50000;
   localparam int CrWr = 50000;
   localparam int CrWg = 41869;
   localparam int CrWb = 8131;
   localparam int ChromaBias = 12800000;
   localparam int ChromaDiv  = 100000;

   // floor(2**shift / divisor); estimate is exact or one low
   localparam int LumaShift   = 18;
   localparam int LumaRecip   = 262;
   localparam int ChromaShift = 25;
   localparam int ChromaRecip = 335;

   localparam int RecipWidth = 9;

   typedef logic [LumaNumWidth-1:0]   luma_num_type;
   typedef logic [ChromaNumWidth-1:0] chroma_num_type;

   // lane 0 is the left pixel, lane 1 the right one
   typedef struct packed {
      luma_num_type   [1:0] y_num;
      chroma_num_type [1:0] cb_num;
      chroma_num_type [1:0] cr_num;
   } num_type;

   typedef struct packed {
      luma_num_type   [1:0] y_num;
      chroma_num_type [1:0] cb_num;
      chroma_num_type [1:0] cr_num;
      logic [1:0][7:0]      y_est;
      logic [1:0][7:0]      cb_est;
      logic [1:0][7:0]      cr_est;
   } est_type;

   typedef struct packed {
      logic [1:0][7:0] y_q;
      logic [1:0][7:0] cb_q;
      logic [1:0][7:0] cr_q;
   } quot_type;

   function automatic luma_num_type luma_num(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      luma_num = LumaNumWidth'(LumaWr * r + LumaWg * g + LumaWb * b);
   endfunction

   // the sum never goes negative, so modular 32-bit math is exact
   function automatic chroma_num_type cb_num(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      cb_num = ChromaNumWidth'(CbWb * b + ChromaBias - CbWr * r - CbWg * g);
   endfunction

   function automatic chroma_num_type cr_num(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      cr_num = ChromaNumWidth'(CrWr * r + ChromaBias - CrWg * g - CrWb * b);
   endfunction

   function automatic logic [7:0] luma_est(input luma_num_type n);
      logic [LumaNumWidth+RecipWidth-1:0] p;
      p = LumaNumWidth'(n) * RecipWidth'(LumaRecip);
      luma_est = p[LumaShift+7:LumaShift];
   endfunction

   function automatic logic [7:0] chroma_est(input chroma_num_type n);
      logic [ChromaNumWidth+RecipWidth-1:0] p;
      p = ChromaNumWidth'(n) * RecipWidth'(ChromaRecip);
      chroma_est = p[ChromaShift+7:ChromaShift];
   endfunction

   function automatic luma_num_type luma_rem(input luma_num_type n, input logic [7:0] q);
      luma_rem = n - LumaNumWidth'(q * LumaDiv);
   endfunction

   function automatic chroma_num_type chroma_rem(input chroma_num_type n,
                                                 input logic [7:0] q);
      chroma_rem = n - ChromaNumWidth'(q * ChromaDiv);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb_pair_to_ycbcr422.sv
// Top level: RGB pixel pair to one YCbCr 4:2:2 item (Y1, Cb, Y2, Cr),
// full-range BT.601 weights. Uses rgb422_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid/req_stall, req_{red,green,blue}_{a,b} | in
//   response| rsp_valid/rsp_stall, rsp_luma_a/b, rsp_chroma_blue/red | out
//
// Four register stages: weighted sums, reciprocal multiply, remainder
// correction, chroma averaging into the output register. One item enters
// per cycle unless req_stall is high. Reset clears the stage valid bits
// only. A stall holds only the stages that are full, so empty stages still
// fill behind a waiting result.
`default_nettype none

module rgb_pair_to_ycbcr422
   import rgb422_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red_a,
   input  wire logic [7:0] req_green_a,
   input  wire logic [7:0] req_blue_a,
   input  wire logic [7:0] req_red_b,
   input  wire logic [7:0] req_green_b,
   input  wire logic [7:0] req_blue_b,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_luma_a,
   output logic [7:0]      rsp_chroma_blue,
   output logic [7:0]      rsp_luma_b,
   output logic [7:0]      rsp_chroma_red
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   num_type  s1_ff, s1_in;
   est_type  s2_ff, s2_in;
   quot_type s3_ff, s3_in;

   logic [7:0] luma_a_ff, luma_b_ff, cb_ff, cr_ff;
   logic [7:0] luma_a_in, luma_b_in, cb_in, cr_in;

   luma_num_type   [1:0] y_rem;
   chroma_num_type [1:0] cb_rem;
   chroma_num_type [1:0] cr_rem;

   logic [8:0] cb_sum, cr_sum;

   // a stage loads when empty or when the next one loads
   assign s4_ready  = !v4_ff || !rsp_stall;
   assign s3_ready  = !v3_ff || s4_ready;
   assign s2_ready  = !v2_ff || s3_ready;
   assign s1_ready  = !v1_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign v1_in = s1_ready ? req_valid : v1_ff;
   assign v2_in = s2_ready ? v1_ff : v2_ff;
   assign v3_in = s3_ready ? v2_ff : v3_ff;
   assign v4_in = s4_ready ? v3_ff : v4_ff;

   // stage 1: weighted sums
   always_comb begin
      s1_in.y_num[0]  = luma_num(req_red_a, req_green_a, req_blue_a);
      s1_in.y_num[1]  = luma_num(req_red_b, req_green_b, req_blue_b);
      s1_in.cb_num[0] = cb_num(req_red_a, req_green_a, req_blue_a);
      s1_in.cb_num[1] = cb_num(req_red_b, req_green_b, req_blue_b);
      s1_in.cr_num[0] = cr_num(req_red_a, req_green_a, req_blue_a);
      s1_in.cr_num[1] = cr_num(req_red_b, req_green_b, req_blue_b);
   end

   // stage 2: quotient estimates by reciprocal multiply
   always_comb begin
      s2_in.y_num  = s1_ff.y_num;
      s2_in.cb_num = s1_ff.cb_num;
      s2_in.cr_num = s1_ff.cr_num;
      for (int l = 0; l < 2; l++) begin
         s2_in.y_est[l]  = luma_est(s1_ff.y_num[l]);
         s2_in.cb_est[l] = chroma_est(s1_ff.cb_num[l]);
         s2_in.cr_est[l] = chroma_est(s1_ff.cr_num[l]);
      end
   end

   // stage 3: estimate is exact or one low; bump when remainder reaches divisor
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         y_rem[l]  = luma_rem(s2_ff.y_num[l], s2_ff.y_est[l]);
         cb_rem[l] = chroma_rem(s2_ff.cb_num[l], s2_ff.cb_est[l]);
         cr_rem[l] = chroma_rem(s2_ff.cr_num[l], s2_ff.cr_est[l]);
         s3_in.y_q[l]  = s2_ff.y_est[l]
                       + 8'(y_rem[l] >= LumaNumWidth'(LumaDiv));
         s3_in.cb_q[l] = s2_ff.cb_est[l]
                       + 8'(cb_rem[l] >= ChromaNumWidth'(ChromaDiv));
         s3_in.cr_q[l] = s2_ff.cr_est[l]
                       + 8'(cr_rem[l] >= ChromaNumWidth'(ChromaDiv));
      end
   end

   // stage 4: floor of the mean of the two chroma values
   assign cb_sum    = {1'b0, s3_ff.cb_q[0]} + {1'b0, s3_ff.cb_q[1]};
   assign cr_sum    = {1'b0, s3_ff.cr_q[0]} + {1'b0, s3_ff.cr_q[1]};
   assign luma_a_in = s3_ff.y_q[0];
   assign luma_b_in = s3_ff.y_q[1];
   assign cb_in     = cb_sum[8:1];
   assign cr_in     = cr_sum[8:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (s4_ready) begin
         luma_a_ff <= luma_a_in;
         luma_b_ff <= luma_b_in;
         cb_ff     <= cb_in;
         cr_ff     <= cr_in;
      end
   end

   assign rsp_valid       = v4_ff;
   assign rsp_luma_a      = luma_a_ff;
   assign rsp_luma_b      = luma_b_ff;
   assign rsp_chroma_blue = cb_ff;
   assign rsp_chroma_red  = cr_ff;

`ifndef SYNTHESIS
   a_luma_est_close: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (y_rem[0] < LumaNumWidth'(2 * LumaDiv))
             && (y_rem[1] < LumaNumWidth'(2 * LumaDiv)))
      else $error("luma reciprocal estimate off by more than one");

   a_chroma_est_close: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (cb_rem[0] < ChromaNumWidth'(2 * ChromaDiv))
             && (cb_rem[1] < ChromaNumWidth'(2 * ChromaDiv))
             && (cr_rem[0] < ChromaNumWidth'(2 * ChromaDiv))
             && (cr_rem[1] < ChromaNumWidth'(2 * ChromaDiv)))
      else $error("chroma reciprocal estimate off by more than one");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && rsp_stall) |=> (v3_ff && $stable(s3_ff)))
      else $error("stage 3 item lost or changed under stall");
`endif

endmodule

`default_nettype wire
